// File: src/rlgd_pkg.sv
`default_nettype none

package rlgd_pkg;

    localparam int MAX_GLYPH_DEF = 64;
    localparam int GLYPH_MIN     = 8;
    localparam int SIZE_W        = 7;
    localparam int COL_W         = 6;
    localparam int LEN_W         = 7;
    localparam int STEP_W        = 4;

    localparam logic [2:0] ST_WORD      = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_ZERO_DRAW = 3'd2;
    localparam logic [2:0] ST_ROW_SHORT = 3'd3;
    localparam logic [2:0] ST_OVERRUN   = 3'd4;

    typedef struct packed {
        logic       capture;
        logic       step;
        logic       out_load;
        logic [2:0] out_status;
        logic       out_last;
        logic       set_halt;
    } rlgd_cmd_t;

    typedef struct packed {
        logic halted;
        logic len_zero;
        logic drawn;
        logic col_zero;
        logic rows_full;
        logic word_emit;
        logic word_last;
        logic rem_done;
    } rlgd_sts_t;

endpackage

`default_nettype wire

// File: src/run_length_glyph_decoder_core.sv
// Items are taken only in the idle state; each is captured, then decoded in steps
//   of up to 8 pixels, each ending at a word edge, a row end or the run's end.
//   No new item is taken until the last one is through. An overrun, or a marker
//   or zero-length item, may end the glyph with a status word; an item offered
//   while halted is accepted but dropped. Output stalls hold the step sequencer.
// Reset (rst_n, async low): position, row count, mask and halt cleared, size = 8.
`default_nettype none

module run_length_glyph_decoder_core
    import rlgd_pkg::*;
#(
    parameter int MAX_GLYPH = MAX_GLYPH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        code,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [5:0]             row,
    output logic [2:0]             word_index,
    output logic [7:0]             coverage,
    output logic [2:0]             status,
    output logic                   last
);

    rlgd_cmd_t cmd;
    rlgd_sts_t sts;

    rlgd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rlgd_datapath #(
        .MAX_GLYPH (MAX_GLYPH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .code       (code),
        .cmd        (cmd),
        .sts        (sts),
        .row        (row),
        .word_index (word_index),
        .coverage   (coverage),
        .status     (status),
        .last       (last)
    );

endmodule

`default_nettype wire

// File: src/rlgd_ctrl.sv
`default_nettype none

module rlgd_ctrl
    import rlgd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire rlgd_sts_t sts,
    output rlgd_cmd_t      cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !sts.halted)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RUN;
                end
            end
            S_RUN:
            begin
                if (slot_free)
                begin
                    if (sts.len_zero)
                    begin
                        state_next = S_IDLE;
                        if (sts.drawn)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_ZERO_DRAW;
                            cmd.out_last   = 1'b1;
                            cmd.set_halt   = 1'b1;
                        end
                        else if (!sts.col_zero)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_ROW_SHORT;
                            cmd.out_last   = 1'b1;
                            cmd.set_halt   = 1'b1;
                        end
                        else if (sts.rows_full)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_DONE;
                            cmd.out_last   = 1'b1;
                            cmd.set_halt   = 1'b1;
                        end
                    end
                    else if (sts.rows_full)
                    begin
                        state_next     = S_IDLE;
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_OVERRUN;
                        cmd.out_last   = 1'b1;
                        cmd.set_halt   = 1'b1;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                        if (sts.word_emit)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_WORD;
                            cmd.out_last   = sts.word_last;
                        end
                        if (sts.rem_done)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: src/rlgd_datapath.sv
`default_nettype none

module rlgd_datapath
    import rlgd_pkg::*;
#(
    parameter int MAX_GLYPH = MAX_GLYPH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [SIZE_W-1:0]  cfg_wdata,
    input  wire logic [7:0]         code,
    input  wire rlgd_cmd_t          cmd,
    output rlgd_sts_t               sts,
    output logic [5:0]              row,
    output logic [2:0]              word_index,
    output logic [7:0]              coverage,
    output logic [2:0]              status,
    output logic                    last
);

    localparam logic [SIZE_W-1:0] MinSize = SIZE_W'(GLYPH_MIN);
    localparam logic [SIZE_W-1:0] MaxSize = SIZE_W'(MAX_GLYPH);

    logic [SIZE_W-1:0] glyph_size_reg;
    logic [COL_W-1:0]  column_reg, column_next;
    logic [SIZE_W-1:0] row_count_reg, row_count_next;
    logic [7:0]        pending_mask_reg, pending_mask_next;
    logic              halted_reg;
    logic              drawn_reg;
    logic [LEN_W-1:0]  rem_reg, rem_next;

    logic [5:0]        row_reg;
    logic [2:0]        word_index_reg;
    logic [7:0]        coverage_reg;
    logic [2:0]        status_reg;
    logic              last_reg;

    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] col_ext;
    logic              col_past;
    logic [SIZE_W-1:0] to_row;
    logic [SIZE_W-1:0] to_word;
    logic [SIZE_W-1:0] lim;
    logic [STEP_W-1:0] k;
    logic [SIZE_W-1:0] newcol;
    logic [SIZE_W-1:0] newcol_m1;
    logic              row_wrap;
    logic              boundary;
    logic [15:0]       ones;
    logic [15:0]       shifted;
    logic [7:0]        merged;
    logic [SIZE_W-1:0] row_after;
    logic [COL_W-1:0]  col_after;
    logic [LEN_W-1:0]  rem_after;
    logic [SIZE_W-1:0] next_diff;
    logic [SIZE_W-1:0] next_lim;

    always_comb
    begin
        if (glyph_size_reg < MinSize)
        begin
            size = MinSize;
        end
        else if (glyph_size_reg > MaxSize)
        begin
            size = MaxSize;
        end
        else
        begin
            size = glyph_size_reg;
        end
    end

    // one step runs to the next word edge, the row end or the end of the run
    always_comb
    begin
        col_ext   = {1'b0, column_reg};
        col_past  = (col_ext >= size);
        to_row    = size - col_ext;
        to_word   = SIZE_W'(8) - SIZE_W'(column_reg[2:0]);
        if (col_past)
        begin
            lim = SIZE_W'(1);
        end
        else if (to_row < to_word)
        begin
            lim = to_row;
        end
        else
        begin
            lim = to_word;
        end
        k         = (rem_reg < lim) ? STEP_W'(rem_reg) : STEP_W'(lim);
        newcol    = col_ext + SIZE_W'(k);
        newcol_m1 = newcol - SIZE_W'(1);
        row_wrap  = (newcol >= size);
        boundary  = (newcol[2:0] == 3'd0) || row_wrap;
        ones      = (16'd1 << k) - 16'd1;
        shifted   = ones << column_reg[2:0];
        merged    = pending_mask_reg | (drawn_reg ? shifted[7:0] : 8'd0);
        row_after = row_count_reg + SIZE_W'(row_wrap);
        col_after = row_wrap ? '0 : newcol[COL_W-1:0];
        rem_after = rem_reg - LEN_W'(k);
        next_diff = size - {1'b0, col_after};
        next_lim  = (next_diff < SIZE_W'(8)) ? next_diff : SIZE_W'(8);
    end

    always_comb
    begin
        sts.halted    = halted_reg;
        sts.len_zero  = (rem_reg == '0);
        sts.drawn     = drawn_reg;
        sts.col_zero  = (column_reg == '0);
        sts.rows_full = (row_count_reg >= size);
        sts.word_emit = boundary;
        sts.word_last = (rem_after == '0)
                        || ((row_after < size) && (rem_after < next_lim));
        sts.rem_done  = (rem_after == '0);
    end

    always_comb
    begin
        column_next       = column_reg;
        row_count_next    = row_count_reg;
        pending_mask_next = pending_mask_reg;
        rem_next          = rem_reg;
        if (cmd.capture)
        begin
            rem_next = code[7:1];
        end
        else if (cmd.step)
        begin
            column_next       = col_after;
            row_count_next    = row_after;
            pending_mask_next = boundary ? 8'd0 : merged;
            rem_next          = rem_after;
        end
        else if (cmd.set_halt)
        begin
            pending_mask_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_size_reg   <= SIZE_W'(GLYPH_MIN);
            column_reg       <= '0;
            row_count_reg    <= '0;
            pending_mask_reg <= '0;
            halted_reg       <= 1'b0;
            rem_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                glyph_size_reg <= cfg_wdata;
            end
            column_reg       <= column_next;
            row_count_reg    <= row_count_next;
            pending_mask_reg <= pending_mask_next;
            rem_reg          <= rem_next;
            if (cmd.set_halt)
            begin
                halted_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            drawn_reg <= code[0];
        end
        if (cmd.out_load)
        begin
            status_reg <= cmd.out_status;
            last_reg   <= cmd.out_last;
            if (cmd.out_status == ST_WORD)
            begin
                row_reg        <= row_count_reg[5:0];
                word_index_reg <= newcol_m1[5:3];
                coverage_reg   <= merged;
            end
            else
            begin
                row_reg        <= '0;
                word_index_reg <= '0;
                coverage_reg   <= '0;
            end
        end
    end

    assign row        = row_reg;
    assign word_index = word_index_reg;
    assign coverage   = coverage_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire
